// File: src/ism_pkg.sv
// Shared types, codes and constants of the interval set merge and match block.
`default_nettype none
package ism_pkg;

	localparam int TABLE_DEPTH_DEF = 512;
	localparam int VAL_W           = 64;
	localparam int RANGES_W        = 10;

	// Operation codes carried in the action field
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_ORDER = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_WRITE,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic             action;
		logic [VAL_W-1:0] low_value;
		logic [VAL_W-1:0] high_value;
	} req_t;

	typedef struct packed {
		logic                matched;
		status_t             status;
		logic [VAL_W-1:0]    covered_count;
		logic [VAL_W-1:0]    hit_count;
		logic [RANGES_W-1:0] ranges_held;
	} rsp_t;

	// One table word: valid flag and closed bounds
	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] lo;
		logic [VAL_W-1:0] hi;
	} entry_t;

endpackage
`default_nettype wire

// File: src/ism_req_if.sv
// Request channel: valid/ready handshake carrying one request item.
`default_nettype none
interface ism_req_if;
	logic          valid;
	logic          ready;
	ism_pkg::req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: src/ism_rsp_if.sv
// Result channel: valid/ready handshake carrying one result item.
`default_nettype none
interface ism_rsp_if;
	logic          valid;
	logic          ready;
	ism_pkg::rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: src/interval_set_merge_and_match_core.sv
// Top level: range table in one memory, scanned once per item.
//
//  channel | dir | payload                                        | handshake
//  --------+-----+------------------------------------------------+----------
//  req     | in  | action, low_value, high_value                  | valid/ready
//  rsp     | out | matched, status, covered_count, hit_count,     | valid/ready
//          |     | ranges_held                                    |
//
// Each item runs in order from accept to result: the table entries are read in turn,
// the last entry is folded in, the read stage drains, the merged range is written back
// and the result is loaded; the block then returns to idle for the next accept.
// After reset a clearing pass marks every entry free;
// req.ready stays low meanwhile. Items are taken one at a time; a result waiting
// in the output register does not block the next accept, only the next result.
`default_nettype none
module interval_set_merge_and_match_core #(
	parameter int TABLE_DEPTH = ism_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ism_req_if.sink     req,
	ism_rsp_if.source   rsp
);

	localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int VW   = ism_pkg::VAL_W;
	localparam int RH_W = ism_pkg::RANGES_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [CW-1:0] LAST_C  = CW'(TABLE_DEPTH - 1);

	function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a,
		input logic [VW-1:0] b);
		logic [VW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[VW] ? {VW{1'b1}} : s[VW-1:0];
	endfunction

	function automatic logic [VW-1:0] span_size(input logic [VW-1:0] lo,
		input logic [VW-1:0] hi);
		logic [VW-1:0] d;
		d = hi - lo;
		return (d == {VW{1'b1}}) ? d : d + VW'(1);
	endfunction

	// Range memory
	ism_pkg::entry_t mem [TABLE_DEPTH];
	ism_pkg::entry_t rd_s1;
	logic            rd_en;
	logic [IW-1:0]   rd_addr;
	logic            wr_en;
	logic [IW-1:0]   wr_addr;
	ism_pkg::entry_t wr_data;

	// Control
	ism_pkg::state_t state_q, state_d;
	logic [CW-1:0]   cnt_q;
	logic            vld_s1;
	logic [IW-1:0]   idx_s1;
	logic            load_out;
	logic            accept;

	// Item context
	ism_pkg::req_t   item_q;
	logic            bad_q;
	logic [VW-1:0]   new_lo_q, new_hi_q;
	logic [IW-1:0]   tgt_q, free_q;
	logic            tgt_found_q, free_found_q;
	logic [VW-1:0]   sum_q;
	logic            hit_q;
	ism_pkg::status_t status_q;

	// Block state
	logic [CW-1:0]   count_q;
	logic [VW-1:0]   cover_q;
	logic [VW-1:0]   match_q;

	// Output register
	ism_pkg::rsp_t   out_q;
	logic            out_valid_q;

	// Scan decode
	logic            is_ins, ins_live, overlap, absorb_extra, in_range, issue, commit;

	assign is_ins   = (item_q.action == ism_pkg::ACT_INSERT);
	assign ins_live = is_ins && !bad_q;
	assign overlap  = rd_s1.valid && !(rd_s1.hi < item_q.low_value ||
		rd_s1.lo > item_q.high_value);
	assign in_range = rd_s1.valid && item_q.low_value >= rd_s1.lo &&
		item_q.low_value <= rd_s1.hi;
	assign absorb_extra = vld_s1 && ins_live && overlap && tgt_found_q;
	assign issue    = (cnt_q != DEPTH_C);
	assign commit   = ins_live && (tgt_found_q || free_found_q);
	assign accept   = req.valid && req.ready;

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	// Next state, memory control and handshake
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = cnt_q[IW-1:0];
		wr_en     = 1'b0;
		wr_addr   = cnt_q[IW-1:0];
		wr_data   = '0;
		load_out  = 1'b0;
		case (state_q)
			ism_pkg::S_INIT: begin
				wr_en = 1'b1;
				if (cnt_q == LAST_C) begin
					state_d = ism_pkg::S_IDLE;
				end
			end
			ism_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ism_pkg::S_SCAN;
				end
			end
			ism_pkg::S_SCAN: begin
				rd_en = issue;
				if (absorb_extra) begin
					wr_en   = 1'b1;
					wr_addr = idx_s1;
					wr_data = '{valid: 1'b0, lo: rd_s1.lo, hi: rd_s1.hi};
				end
				if (!issue && !vld_s1) begin
					state_d = ism_pkg::S_WRITE;
				end
			end
			ism_pkg::S_WRITE: begin
				if (commit) begin
					wr_en   = 1'b1;
					wr_addr = tgt_found_q ? tgt_q : free_q;
					wr_data = '{valid: 1'b1, lo: new_lo_q, hi: new_hi_q};
				end
				state_d = ism_pkg::S_FINISH;
			end
			ism_pkg::S_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ism_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ism_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ism_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Write and read the range memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s1 <= mem[rd_addr];
		end
		idx_s1 <= rd_addr;
	end

	// Advance the sweep counter and the read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			if (state_q == ism_pkg::S_INIT) begin
				cnt_q <= (cnt_q == LAST_C) ? '0 : cnt_q + CW'(1);
			end else if (accept) begin
				cnt_q <= '0;
			end else if (state_q == ism_pkg::S_SCAN && issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// Capture the item and fold each scanned entry into the context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			hit_q        <= 1'b0;
			bad_q        <= 1'b0;
			count_q      <= '0;
			cover_q      <= '0;
			match_q      <= '0;
			status_q     <= ism_pkg::STAT_OK;
		end else begin
			if (accept) begin
				bad_q        <= (req.payload.action == ism_pkg::ACT_INSERT) &&
					(req.payload.low_value > req.payload.high_value);
				tgt_found_q  <= 1'b0;
				free_found_q <= 1'b0;
				hit_q        <= 1'b0;
			end
			if (state_q == ism_pkg::S_SCAN && vld_s1) begin
				if (!is_ins) begin
					if (in_range) begin
						hit_q <= 1'b1;
					end
				end else if (!bad_q) begin
					if (!rd_s1.valid) begin
						if (!free_found_q) begin
							free_found_q <= 1'b1;
						end
					end else if (overlap) begin
						if (!tgt_found_q) begin
							tgt_found_q <= 1'b1;
						end else begin
							count_q <= count_q - CW'(1);
						end
					end
				end
			end
			if (state_q == ism_pkg::S_WRITE) begin
				if (!is_ins) begin
					status_q <= ism_pkg::STAT_OK;
					if (hit_q) begin
						match_q <= sat_add(match_q, VW'(1));
					end
				end else if (bad_q) begin
					status_q <= ism_pkg::STAT_ORDER;
				end else if (commit) begin
					status_q <= ism_pkg::STAT_OK;
					cover_q  <= sat_add(sum_q, span_size(new_lo_q, new_hi_q));
					if (!tgt_found_q) begin
						count_q <= count_q + CW'(1);
					end
				end else begin
					status_q <= ism_pkg::STAT_FULL;
				end
			end
		end
	end

	// Hold the item payload and the merge accumulators
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q   <= req.payload;
			new_lo_q <= req.payload.low_value;
			new_hi_q <= req.payload.high_value;
			sum_q    <= '0;
		end
		if (state_q == ism_pkg::S_SCAN && vld_s1 && ins_live) begin
			if (!rd_s1.valid) begin
				if (!free_found_q) begin
					free_q <= idx_s1;
				end
			end else if (overlap) begin
				if (rd_s1.lo < new_lo_q) begin
					new_lo_q <= rd_s1.lo;
				end
				if (rd_s1.hi > new_hi_q) begin
					new_hi_q <= rd_s1.hi;
				end
				if (!tgt_found_q) begin
					tgt_q <= idx_s1;
				end
			end else begin
				sum_q <= sat_add(sum_q, span_size(rd_s1.lo, rd_s1.hi));
			end
		end
	end

	// Load the result and drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.matched       <= !is_ins && hit_q;
			out_q.status        <= status_q;
			out_q.covered_count <= cover_q;
			out_q.hit_count     <= match_q;
			out_q.ranges_held   <= RH_W'(count_q);
		end
	end

endmodule
`default_nettype wire

// File: src/ism_checker.sv
// Port-level checks of the interval set merge and match block, bound to its top level.
`default_nettype none
module ism_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire ism_pkg::rsp_t rsp_payload
);

	// A stalled result holds its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("result changed while stalled");

	// One item in flight: no accept in the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted twice in a row");

	// A match comes only with an ok status
	a_match_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.matched |-> rsp_payload.status == ism_pkg::STAT_OK)
		else $error("match with refusal status");

	// A match is counted in the hit total
	a_match_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.matched |-> rsp_payload.hit_count != '0)
		else $error("match with zero hit count");

endmodule

bind interval_set_merge_and_match_core ism_checker u_ism_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);
`default_nettype wire

// File: test/ism_result_checker.sv
// Checker for the interval set core: tracks the range table, predicts each result and compares.
`default_nettype none
module ism_result_checker #(
	parameter int TABLE_DEPTH = ism_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ism_req_if        req,
	ism_rsp_if        rsp,
	output int        fail_count,
	output int        pending
);
	import ism_pkg::*;

	localparam logic [VAL_W-1:0] TOP_VALUE = '1;

	// Shadow copy of the range table and the running totals
	logic [VAL_W-1:0] span_lo   [TABLE_DEPTH];
	logic [VAL_W-1:0] span_hi   [TABLE_DEPTH];
	logic             span_used [TABLE_DEPTH];
	logic [VAL_W-1:0] cover_sum;
	logic [VAL_W-1:0] hit_sum;
	int               span_count;
	rsp_t             predicted_q [$];

	function automatic logic [VAL_W-1:0] add_capped(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		logic [VAL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[VAL_W] ? TOP_VALUE : s[VAL_W-1:0];
	endfunction

	// Number of values in lo..hi; the whole space caps at the top value
	function automatic logic [VAL_W-1:0] span_size(input logic [VAL_W-1:0] lo,
			input logic [VAL_W-1:0] hi);
		if (lo == '0 && hi == TOP_VALUE) begin
			return TOP_VALUE;
		end
		return hi - lo + 64'd1;
	endfunction

	function automatic logic holds_value(input logic [VAL_W-1:0] v);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (span_used[i] && v >= span_lo[i] && v <= span_hi[i]) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Merge lo..hi with every overlapping entry, then recount the cover
	task automatic merge_range(input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi,
			output status_t st);
		logic [VAL_W-1:0] new_lo;
		logic [VAL_W-1:0] new_hi;
		logic [VAL_W-1:0] sum;
		int               keep;
		int               free_slot;
		st = STAT_OK;
		new_lo = lo;
		new_hi = hi;
		keep = -1;
		free_slot = -1;
		if (lo > hi) begin
			st = STAT_ORDER;
			return;
		end
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (!span_used[i]) begin
				if (free_slot < 0) free_slot = i;
			end else if (!(span_hi[i] < lo || span_lo[i] > hi)) begin
				if (span_lo[i] < new_lo) new_lo = span_lo[i];
				if (span_hi[i] > new_hi) new_hi = span_hi[i];
				if (keep < 0) begin
					keep = i;
				end else begin
					span_used[i] = 1'b0;
					span_count--;
				end
			end
		end
		// nothing absorbed: take the lowest free slot or refuse
		if (keep < 0) begin
			if (free_slot < 0) begin
				st = STAT_FULL;
				return;
			end
			keep = free_slot;
			span_used[keep] = 1'b1;
			span_count++;
		end
		span_lo[keep] = new_lo;
		span_hi[keep] = new_hi;
		sum = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (span_used[i]) sum = add_capped(sum, span_size(span_lo[i], span_hi[i]));
		end
		cover_sum = sum;
	endtask

	task automatic predict_result(input req_t it, output rsp_t res);
		status_t st;
		st = STAT_OK;
		res = '0;
		if (it.action == ACT_INSERT) begin
			merge_range(it.low_value, it.high_value, st);
		end else if (holds_value(it.low_value)) begin
			res.matched = 1'b1;
			hit_sum = add_capped(hit_sum, 64'd1);
		end
		res.status        = st;
		res.covered_count = cover_sum;
		res.hit_count     = hit_sum;
		res.ranges_held   = RANGES_W'(span_count);
	endtask

	task automatic compare_result(input rsp_t want, input rsp_t got);
		if (got.matched !== want.matched) begin
			$error("matched: expected %0d, got %0d", want.matched, got.matched);
			fail_count++;
		end
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			fail_count++;
		end
		if (got.covered_count !== want.covered_count) begin
			$error("covered_count: expected %0h, got %0h", want.covered_count,
				got.covered_count);
			fail_count++;
		end
		if (got.hit_count !== want.hit_count) begin
			$error("hit_count: expected %0d, got %0d", want.hit_count, got.hit_count);
			fail_count++;
		end
		if (got.ranges_held !== want.ranges_held) begin
			$error("ranges_held: expected %0d, got %0d", want.ranges_held, got.ranges_held);
			fail_count++;
		end
	endtask

	// Check each result against the oldest prediction, then predict each new item
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) span_used[i] = 1'b0;
			cover_sum = '0;
			hit_sum = '0;
			span_count = 0;
			fail_count = 0;
			predicted_q.delete();
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (predicted_q.size() == 0) begin
					$error("result item arrived with no item outstanding");
					fail_count++;
				end else begin
					want = predicted_q.pop_front();
					compare_result(want, rsp.payload);
				end
			end
			if (req.valid && req.ready) begin
				predict_result(req.payload, want);
				predicted_q = {predicted_q, want};
			end
			pending <= predicted_q.size();
		end
	end

endmodule
`default_nettype wire

// File: test/interval_set_merge_and_match_core_tb.sv
// Testbench top for the interval set core: clock, reset, item stimulus, receiver stalls, verdict.
`default_nettype none
module interval_set_merge_and_match_core_tb;
	import ism_pkg::*;

	localparam int               DEPTH           = TABLE_DEPTH_DEF;
	localparam int               IDLE_LIMIT      = 25000;
	localparam int               HOLD_OFF_CYCLES = 3000;
	localparam int               RANDOM_ITEMS    = 600;
	localparam int               FILL_STRIDE     = 4096;
	localparam logic [VAL_W-1:0] FILL_BASE       = 64'h0000_4000_0000_0000;
	localparam logic [VAL_W-1:0] TOP_VALUE       = '1;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	bit   offering;
	int   burst_left;
	bit   hold_off_due;

	ism_req_if req_ch ();
	ism_rsp_if rsp_ch ();

	interval_set_merge_and_match_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	ism_result_checker #(.TABLE_DEPTH(DEPTH)) result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [VAL_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic req_t insert_item(input logic [VAL_W-1:0] lo,
			input logic [VAL_W-1:0] hi);
		req_t it;
		it.action = ACT_INSERT;
		it.low_value = lo;
		it.high_value = hi;
		return it;
	endfunction

	// The upper bound is ignored on a query; fill it with noise
	function automatic req_t query_item(input logic [VAL_W-1:0] v);
		req_t it;
		it.action = ACT_QUERY;
		it.low_value = v;
		it.high_value = rand64();
		return it;
	endfunction

	// Offer one item until taken, then maybe drop valid for a random gap
	task automatic send_item(input req_t it);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.payload <= it;
		offering = 1'b1;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 5);
			case ($urandom_range(0, 19))
				0, 1, 2, 3: gap = 0;
				16, 17, 18, 19: gap = $urandom_range(17, 520);
				default: gap = $urandom_range(1, 16);
			endcase
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				offering = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Hold the sender until every outstanding result has come back
	task automatic drain_results();
		if (offering) begin
			req_ch.valid <= 1'b0;
			offering = 1'b0;
		end
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Receiver: runs of ready and stalls, plus one long hold-off on request
	initial begin : rsp_side
		int  run;
		int  stall;
		bit  ready_now;
		ready_now = 1'b0;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_off_due) begin
				hold_off_due = 1'b0;
				if (ready_now) begin
					rsp_ch.ready <= 1'b0;
					ready_now = 1'b0;
				end
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			run = ($urandom_range(0, 19) < 17) ? $urandom_range(1, 25)
				: $urandom_range(200, 2000);
			if (!ready_now) begin
				rsp_ch.ready <= 1'b1;
				ready_now = 1'b1;
			end
			repeat (run) @(posedge clk);
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6: stall = 0;
				17, 18, 19: stall = $urandom_range(100, 600);
				default: stall = $urandom_range(1, 30);
			endcase
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				ready_now = 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// End the run when nothing moves on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		logic [VAL_W-1:0] win_base;
		logic [VAL_W-1:0] lo;
		logic [VAL_W-1:0] hi;
		logic [VAL_W-1:0] v;
		logic [VAL_W-1:0] seen_lo [16];
		logic [VAL_W-1:0] seen_hi [16];
		int               seen_n;
		int               seen_wr;
		int               idx;
		int               roll;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.payload <= '0;
		offering = 1'b0;
		burst_left = 0;
		hold_off_due = 1'b0;
		seen_n = 0;
		seen_wr = 0;
		win_base = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reversed bounds, extremes, touching and merging ranges
		send_item(insert_item(64'd5, 64'd4));
		send_item(insert_item(TOP_VALUE, 64'd0));
		send_item(query_item(64'd0));
		send_item(insert_item(64'd0, 64'd0));
		send_item(insert_item(TOP_VALUE, TOP_VALUE));
		send_item(query_item(64'd0));
		send_item(query_item(TOP_VALUE));
		send_item(query_item(64'd1));
		send_item(insert_item(64'd10, 64'd20));
		send_item(insert_item(64'd21, 64'd30));
		send_item(insert_item(64'd1, 64'd9));
		send_item(query_item(64'd21));
		send_item(insert_item(64'd15, 64'd25));
		send_item(insert_item(64'd30, 64'd40));
		send_item(insert_item(64'd12, 64'd13));
		send_item(query_item(64'd40));
		send_item(query_item(64'd41));
		send_item(insert_item(64'd0, 64'd100));
		send_item(query_item(64'd100));

		// fill the table with disjoint ranges until inserts are refused
		for (int k = 0; k < DEPTH + 4; k++) begin
			lo = FILL_BASE + 64'(k) * FILL_STRIDE + 64'($urandom_range(0, 1000));
			hi = lo + 64'($urandom_range(0, 2000));
			send_item(insert_item(lo, hi));
		end
		// absorb into a held entry while full, then one more refusal
		send_item(insert_item(FILL_BASE + 64'(7 * FILL_STRIDE),
			FILL_BASE + 64'(7 * FILL_STRIDE + 1000)));
		send_item(insert_item(FILL_BASE + 64'((DEPTH + 8) * FILL_STRIDE),
			FILL_BASE + 64'((DEPTH + 8) * FILL_STRIDE + 5)));
		drain_results();
		send_item(query_item(FILL_BASE + 64'(7 * FILL_STRIDE + 500)));
		send_item(query_item(FILL_BASE + 64'(7 * FILL_STRIDE + 3500)));
		send_item(insert_item(FILL_BASE + 64'(20 * FILL_STRIDE),
			FILL_BASE + 64'(300 * FILL_STRIDE)));

		// random phase; the receiver holds off once at its start
		hold_off_due = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				win_base = ($urandom_range(0, 1) == 1)
					? FILL_BASE + 64'($urandom_range(0, 400 * FILL_STRIDE))
					: rand64() & ~64'hFFFF_FFFF;
			end
			roll = $urandom_range(0, 99);
			if (roll < 40) begin
				// insert a short range inside the current window
				lo = win_base + 64'($urandom_range(0, 65535));
				case ($urandom_range(0, 9))
					0: hi = lo;
					1, 2, 3: hi = lo + 64'($urandom_range(0, 4000));
					default: hi = lo + 64'($urandom_range(0, 300));
				endcase
				if (hi < lo) hi = TOP_VALUE;
				seen_lo[seen_wr] = lo;
				seen_hi[seen_wr] = hi;
				seen_wr = (seen_wr + 1) % 16;
				if (seen_n < 16) seen_n++;
				send_item(insert_item(lo, hi));
			end else if (roll < 75) begin
				// query near recent bounds, in the window, or anywhere
				idx = $urandom_range(0, 9);
				if (idx < 5 && seen_n > 0) begin
					idx = $urandom_range(0, seen_n - 1);
					case ($urandom_range(0, 3))
						0: v = seen_lo[idx] - 64'd1;
						1: v = seen_lo[idx];
						2: v = seen_hi[idx];
						default: v = seen_hi[idx] + 64'd1;
					endcase
				end else if (idx < 9) begin
					v = win_base + 64'($urandom_range(0, 70000));
				end else begin
					v = rand64();
				end
				send_item(query_item(v));
			end else if (roll < 83) begin
				// reversed bounds, by one or by a random amount
				hi = rand64() >> 1;
				lo = hi + 64'd1 + (($urandom_range(0, 1) == 1) ? 64'd0 : (rand64() >> 1));
				send_item(insert_item(lo, hi));
			end else if (roll < 99) begin
				lo = rand64();
				hi = lo + 64'($urandom_range(0, 1 << 20));
				if (hi < lo) hi = TOP_VALUE;
				send_item(insert_item(lo, hi));
			end else begin
				// wide range anywhere, absorbing much of the table
				lo = rand64();
				hi = rand64();
				if (lo > hi) begin
					v = lo;
					lo = hi;
					hi = v;
				end
				send_item(insert_item(lo, hi));
			end
		end

		// directed: saturating cover with touching ends, then the whole space
		send_item(insert_item(64'd101, TOP_VALUE - 64'd1));
		send_item(query_item(TOP_VALUE));
		send_item(query_item(64'd100));
		send_item(insert_item(64'd0, TOP_VALUE));
		send_item(query_item(rand64()));
		send_item(insert_item(64'd7, 64'd3));

		drain_results();
		repeat (DEPTH + 16) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
`default_nettype wire
